// ===== sv/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared codes, constants, control structs and slice functions of the
// probabilistic distinct counter.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // Request command codes
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_ESTIMATE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SLICE_LOG2 = 1'b0;
    localparam logic CFG_SALT_COUNT = 1'b1;

    localparam int DIGEST_BYTES = 16;
    localparam int DIGEST_BITS  = DIGEST_BYTES * 8;
    localparam int EST_W        = 48;
    localparam int MEAN_W       = 16;

    localparam logic [2:0]  SLICE_LOG2_MAX = 3'd4;
    localparam logic [7:0]  IP_SAT         = 8'd48;
    localparam logic [6:0]  SCALE_SHIFT    = 7'd60;
    localparam logic [31:0] Q30_ONE        = 32'h4000_0000;
    localparam logic [63:0] Q30_HALF       = 64'h0000_0000_2000_0000;
    localparam logic [31:0] INV_FM_Q30     = 32'd1388142137;

    // Q30 values of 2^(2^(b-8)) for fraction bit b
    localparam logic [31:0] ROOT_Q30 [8] = '{
        32'd1076653033, 32'd1079572136, 32'd1085434106, 32'd1097253708,
        32'd1121280436, 32'd1170923762, 32'd1276901417, 32'd1518500250
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic rd_en;
        logic rd_sel_ctr;
        logic wr_en;
        logic clr_valid;
        logic est_init;
        logic mask_en;
        logic pop_en;
        logic sum_en;
        logic div_start;
        logic exp_step;
        logic scale_en;
        logic out_load;
    } pdc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] command;
        logic       salt_ok;
        logic       last_salt;
        logic       div_done;
        logic       exp_last;
        logic       out_free;
    } pdc_status_t;

    // Isolate the lowest set bit of the digest within each slice
    function automatic logic [DIGEST_BITS-1:0] slice_low_bits(
        input logic [DIGEST_BITS-1:0] d,
        input logic [2:0]             lg
    );
        logic [DIGEST_BITS-1:0] r;
        r = '0;
        unique case (lg)
            3'd0: begin
                for (int s = 0; s < 16; s++)
                    r[s*8 +: 8] = d[s*8 +: 8] & (~d[s*8 +: 8] + 8'd1);
            end
            3'd1: begin
                for (int s = 0; s < 8; s++)
                    r[s*16 +: 16] = d[s*16 +: 16] & (~d[s*16 +: 16] + 16'd1);
            end
            3'd2: begin
                for (int s = 0; s < 4; s++)
                    r[s*32 +: 32] = d[s*32 +: 32] & (~d[s*32 +: 32] + 32'd1);
            end
            3'd3: begin
                for (int s = 0; s < 2; s++)
                    r[s*64 +: 64] = d[s*64 +: 64] & (~d[s*64 +: 64] + 64'd1);
            end
            default: begin
                r = d & (~d + 128'd1);
            end
        endcase
        return r;
    endfunction

    // Mask of the run of ones below the lowest zero within each slice
    function automatic logic [DIGEST_BITS-1:0] slice_run_mask(
        input logic [DIGEST_BITS-1:0] b,
        input logic [2:0]             lg
    );
        logic [DIGEST_BITS-1:0] r;
        r = '0;
        unique case (lg)
            3'd0: begin
                for (int s = 0; s < 16; s++)
                    r[s*8 +: 8] = b[s*8 +: 8] & ~(b[s*8 +: 8] + 8'd1);
            end
            3'd1: begin
                for (int s = 0; s < 8; s++)
                    r[s*16 +: 16] = b[s*16 +: 16] & ~(b[s*16 +: 16] + 16'd1);
            end
            3'd2: begin
                for (int s = 0; s < 4; s++)
                    r[s*32 +: 32] = b[s*32 +: 32] & ~(b[s*32 +: 32] + 32'd1);
            end
            3'd3: begin
                for (int s = 0; s < 2; s++)
                    r[s*64 +: 64] = b[s*64 +: 64] & ~(b[s*64 +: 64] + 64'd1);
            end
            default: begin
                r = b & ~(b + 128'd1);
            end
        endcase
        return r;
    endfunction

    // Count ones in a byte
    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) c = c + 4'(b[i]);
        return c;
    endfunction

    // Add sixteen 4-bit byte counts through a four-level tree
    function automatic logic [7:0] sum_bytes(input logic [63:0] cnt);
        logic [4:0] l1 [8];
        logic [5:0] l2 [4];
        logic [6:0] l3 [2];
        for (int i = 0; i < 8; i++)
            l1[i] = 5'(cnt[i*8 +: 4]) + 5'(cnt[i*8+4 +: 4]);
        for (int i = 0; i < 4; i++)
            l2[i] = 6'(l1[2*i]) + 6'(l1[2*i+1]);
        for (int i = 0; i < 2; i++)
            l3[i] = 7'(l2[2*i]) + 7'(l2[2*i+1]);
        return 8'(l3[0]) + 8'(l3[1]);
    endfunction

endpackage

// ===== sv/probabilistic_distinct_counter_top.sv =====
// ----------------------------------------------------------------------------
// probabilistic_distinct_counter_top
// Flajolet-Martin distinct-count sketch with per-salt 128-bit bitmaps.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (valid/ready): add a digest to one salt's
// bitmap, report an estimate, or clear every bitmap. Only an estimate makes
// a result, which leaves on the m_ channel (valid/ready) from an output
// register. Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data
// while the block is idle; the user is bound to this, the block does not enforce it.
// One request is worked at a time, sequenced by the controller:
//   add:      accept, bitmap read, merge write
//   clear:    accept, then decode and clear
//   estimate: accept and decode, then the four-step walk per salt over the
//             single bitmap read port, the one-bit-per-cycle divider and the
//             eight-step fractional power loop, then scale and deliver.
// A stalled receiver does not block adds or clears; a further estimate waits
// in its last step until the output register is free.
// Reset clears every bitmap at once through row valid bits, and loads the
// slice width code 2 and salt count 1.
// ----------------------------------------------------------------------------
module probabilistic_distinct_counter_top #(
    parameter int MAX_SALTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [2:0]  s_salt_index,
    input  logic [63:0] s_digest_low,
    input  logic [63:0] s_digest_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_estimate,
    output logic [15:0] m_mean_run_q8,
    output logic        m_saturated,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wr_data
);
    import pdc_pkg::*;

    pdc_cmd_t    cmd;
    pdc_status_t status;

    pdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    pdc_datapath #(
        .MAX_SALTS (MAX_SALTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_command     (s_command),
        .s_salt_index  (s_salt_index),
        .s_digest_low  (s_digest_low),
        .s_digest_high (s_digest_high),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate),
        .m_mean_run_q8 (m_mean_run_q8),
        .m_saturated   (m_saturated)
    );

endmodule

// ===== sv/pdc_div.sv =====
// ----------------------------------------------------------------------------
// pdc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdc_div #(
    parameter int DIVD_W = 19,
    parameter int DIVS_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVS_W:0] trial;
    logic [DIVS_W:0] diff;
    logic            ge;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    // Control: step count and completion
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: shift in one quotient bit per step
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            rem_reg <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/pdc_datapath.sv =====
// ----------------------------------------------------------------------------
// pdc_datapath
// Bitmap memory, configuration, run counting, divider, exponent and
// output register of the distinct counter.
// ----------------------------------------------------------------------------
module pdc_datapath #(
    parameter int MAX_SALTS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pdc_pkg::pdc_cmd_t   cmd,
    output pdc_pkg::pdc_status_t status,
    input  logic [1:0]          s_command,
    input  logic [2:0]          s_salt_index,
    input  logic [63:0]         s_digest_low,
    input  logic [63:0]         s_digest_high,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_wr_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [47:0]         m_estimate,
    output logic [15:0]         m_mean_run_q8,
    output logic                m_saturated
);
    import pdc_pkg::*;

    localparam int ADDR_W = (MAX_SALTS > 1) ? $clog2(MAX_SALTS) : 1;
    localparam int SALT_W = $clog2(MAX_SALTS + 1);
    localparam int SUM_W  = $clog2(DIGEST_BITS * MAX_SALTS + 1);
    localparam int DIVD_W = SUM_W + 8;

    // Configuration registers
    logic [2:0] lg_reg;
    logic [3:0] salts_reg;

    // Request registers
    logic [1:0]             cmd_reg;
    logic [2:0]             salt_reg;
    logic [DIGEST_BITS-1:0] digest_reg;

    // Bitmap memory and row valid bits
    logic [DIGEST_BITS-1:0] mem [MAX_SALTS];
    logic [MAX_SALTS-1:0]   row_valid_reg;
    logic [DIGEST_BITS-1:0] rdata_reg;
    logic                   rvalid_reg;

    // Estimate datapath registers
    logic [ADDR_W-1:0]      ctr_reg;
    logic [DIGEST_BITS-1:0] mask_reg;
    logic [63:0]            bytecnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [31:0]            acc_reg;
    logic [2:0]             exp_ctr_reg;
    logic [63:0]            prod_reg;

    // Output register
    logic              out_valid_reg;
    logic [EST_W-1:0]  est_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic              sat_reg;

    logic [2:0]             eff_lg;
    logic [SALT_W-1:0]      eff_salts;
    logic [ADDR_W-1:0]      salt_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [DIGEST_BITS-1:0] row;
    logic [DIVD_W-1:0]      dividend;
    logic                   div_done;
    logic [DIVD_W-1:0]      quotient;
    logic [7:0]             frac;
    logic [63:0]            exp_mul;
    logic [7:0]             ip;
    logic [5:0]             shamt;
    logic [63:0]            shifted;
    logic                   sat;

    // Clamp the configuration to its working range
    always_comb begin
        eff_lg = (lg_reg > SLICE_LOG2_MAX) ? SLICE_LOG2_MAX : lg_reg;
        if (salts_reg == 4'd0) begin
            eff_salts = SALT_W'(1);
        end else if (8'(salts_reg) > 8'(MAX_SALTS)) begin
            eff_salts = SALT_W'(MAX_SALTS);
        end else begin
            eff_salts = SALT_W'(salts_reg);
        end
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_reg    <= 3'd2;
            salts_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SLICE_LOG2: lg_reg    <= cfg_wr_data[2:0];
                CFG_SALT_COUNT: salts_reg <= cfg_wr_data;
            endcase
        end
    end

    // Capture the accepted request
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            cmd_reg    <= s_command;
            salt_reg   <= s_salt_index;
            digest_reg <= {s_digest_high, s_digest_low};
        end
    end

    assign salt_addr = ADDR_W'(salt_reg);
    assign rd_addr   = cmd.rd_sel_ctr ? ctr_reg : salt_addr;
    assign row       = rvalid_reg ? rdata_reg : '0;

    // Bitmap memory: registered read, merge write
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.wr_en) begin
            mem[salt_addr] <= row | slice_low_bits(digest_reg, eff_lg);
        end
    end

    // Row valid bits: cleared by reset and the clear command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end else begin
            if (cmd.rd_en) begin
                rvalid_reg <= row_valid_reg[rd_addr];
            end
            if (cmd.clr_valid) begin
                row_valid_reg <= '0;
            end else if (cmd.wr_en) begin
                row_valid_reg[salt_addr] <= 1'b1;
            end
        end
    end

    // Walk the salts: run mask, byte counts, accumulate
    always_ff @(posedge aclk) begin
        if (cmd.est_init) begin
            ctr_reg <= '0;
            sum_reg <= '0;
        end else if (cmd.sum_en) begin
            ctr_reg <= ctr_reg + ADDR_W'(1);
            sum_reg <= sum_reg + SUM_W'(sum_bytes(bytecnt_reg));
        end
        if (cmd.mask_en) begin
            mask_reg <= slice_run_mask(row, eff_lg);
        end
        if (cmd.pop_en) begin
            for (int k = 0; k < 16; k++)
                bytecnt_reg[k*4 +: 4] <= pop8(mask_reg[k*8 +: 8]);
        end
    end

    // Scale the sum by 256 / slices, then divide by the salt count
    assign dividend = DIVD_W'(sum_reg) << (4'(eff_lg) + 4'd4);

    pdc_div #(
        .DIVD_W (DIVD_W),
        .DIVS_W (SALT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (eff_salts),
        .done     (div_done),
        .quotient (quotient)
    );

    // Fractional power of two, one fraction bit per cycle from the top
    assign frac    = quotient[7:0];
    assign exp_mul = 64'(acc_reg) * 64'(ROOT_Q30[exp_ctr_reg]) + Q30_HALF;

    always_ff @(posedge aclk) begin
        if (cmd.est_init) begin
            acc_reg     <= Q30_ONE;
            exp_ctr_reg <= 3'd7;
        end else if (cmd.exp_step) begin
            exp_ctr_reg <= exp_ctr_reg - 3'd1;
            if (frac[exp_ctr_reg]) begin
                acc_reg <= exp_mul[61:30];
            end
        end
        if (cmd.scale_en) begin
            prod_reg <= 64'(acc_reg) * 64'(INV_FM_Q30);
        end
    end

    // Integer part shift and clamp
    assign ip      = quotient[15:8];
    assign shamt   = 6'(SCALE_SHIFT - 7'(ip));
    assign shifted = prod_reg >> shamt;
    assign sat     = (ip >= IP_SAT) || (shifted[63:EST_W] != '0);

    // Output register: load a result, drop it when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            est_reg  <= sat ? {EST_W{1'b1}} : shifted[EST_W-1:0];
            mean_reg <= quotient[MEAN_W-1:0];
            sat_reg  <= sat;
        end
    end

    // Status toward the controller
    always_comb begin
        status.command   = cmd_reg;
        status.salt_ok   = 8'(salt_reg) < 8'(eff_salts);
        status.last_salt = (SALT_W'(ctr_reg) + SALT_W'(1)) == eff_salts;
        status.div_done  = div_done;
        status.exp_last  = exp_ctr_reg == 3'd0;
        status.out_free  = !out_valid_reg || m_ready;
    end

    assign m_valid       = out_valid_reg;
    assign m_estimate    = est_reg;
    assign m_mean_run_q8 = mean_reg;
    assign m_saturated   = sat_reg;

endmodule

// ===== sv/pdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdc_ctrl
// Sequencer of the distinct counter: decodes requests and steps the
// datapath through add, clear and estimate.
// ----------------------------------------------------------------------------
module pdc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output pdc_pkg::pdc_cmd_t    cmd,
    input  pdc_pkg::pdc_status_t status
);
    import pdc_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_DECODE    = 12'b0000_0000_0010,
        ST_ADD_WRITE = 12'b0000_0000_0100,
        ST_EST_READ  = 12'b0000_0000_1000,
        ST_EST_MASK  = 12'b0000_0001_0000,
        ST_EST_POP   = 12'b0000_0010_0000,
        ST_EST_SUM   = 12'b0000_0100_0000,
        ST_DIV_START = 12'b0000_1000_0000,
        ST_DIV_WAIT  = 12'b0001_0000_0000,
        ST_EXP       = 12'b0010_0000_0000,
        ST_SCALE     = 12'b0100_0000_0000,
        ST_DELIVER   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.command)
                    CMD_ADD: begin
                        if (status.salt_ok) begin
                            cmd.rd_en  = 1'b1;
                            state_next = ST_ADD_WRITE;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_ESTIMATE: begin
                        cmd.est_init = 1'b1;
                        state_next   = ST_EST_READ;
                    end
                    CMD_CLEAR: begin
                        cmd.clr_valid = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ADD_WRITE: begin
                cmd.wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EST_READ: begin
                cmd.rd_en      = 1'b1;
                cmd.rd_sel_ctr = 1'b1;
                state_next     = ST_EST_MASK;
            end
            ST_EST_MASK: begin
                cmd.mask_en = 1'b1;
                state_next  = ST_EST_POP;
            end
            ST_EST_POP: begin
                cmd.pop_en = 1'b1;
                state_next = ST_EST_SUM;
            end
            ST_EST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = status.last_salt ? ST_DIV_START : ST_EST_READ;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                cmd.exp_step = 1'b1;
                if (status.exp_last) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale_en = 1'b1;
                state_next   = ST_DELIVER;
            end
            ST_DELIVER: begin
                // Hold until the output register can take the result
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
